>>> rtl/core/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern search unit.
package wbps_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int OFFSET_BITS = 32;
    localparam int COUNT_BITS  = OFFSET_BITS + 1;
    localparam int ADDR_BITS   = 64;
    localparam int LEN_BITS    = 7;
    localparam int EFF_BITS    = $clog2(MAX_PATTERN + 1);
    localparam int SLOT_BITS   = 6;
    localparam int BYTE_BITS   = 8;

    localparam logic [BYTE_BITS-1:0] WILDCARD_BYTE = 8'h2A;

    // Item kinds carried on s_tuser.
    localparam logic ACT_LOAD_PATTERN = 1'b0;
    localparam logic ACT_REGION_BYTE  = 1'b1;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_ADDRESS   = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 1'd1;

    // Broadcast control for the row of cells.
    typedef struct packed {
        logic                 load_en;
        logic [SLOT_BITS-1:0] slot;
        logic                 shift_en;
        logic                 clear;
        logic [BYTE_BITS-1:0] data;
    } cell_ctrl_t;

    // Region byte handed from the input side to the tracker.
    typedef struct packed {
        logic accepted;
        logic last;
    } trk_in_t;

    // Tracker status seen by the input side and the cells.
    typedef struct packed {
        logic hold_input;
        logic clear_search;
    } trk_status_t;

endpackage

>>> rtl/core/wildcard_byte_pattern_search_unit.sv
// A tlast region byte is registered for evaluation, then its result item is registered onto m_*.
// Throughput: one item per cycle; after a tlast byte s_tready drops while the tracker closes the
// region, and stays low while the result register is still waiting on m_tready.
// The window compare runs across all cells in parallel in the cycle after each byte.
// Reset (aresetn low, synchronous) clears window, counters and handshakes; pattern bytes
// stay undefined until loaded, base_address resets to 0 and pattern_length to 1.
module wildcard_byte_pattern_search_unit (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [15:0]                             s_tdata,  // pattern_slot, data_byte
    input  logic                                    s_tuser,  // action
    input  logic                                    s_tlast,  // region_last
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [wbps_pkg::ADDR_BITS-1:0]          m_tdata,  // match_address
    output logic                                    m_tuser,  // found
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [wbps_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [wbps_pkg::ADDR_BITS-1:0]          cfg_data
);

    logic [wbps_pkg::ADDR_BITS-1:0] base_address_reg;
    logic [wbps_pkg::EFF_BITS-1:0]  eff_len_reg;
    logic [wbps_pkg::EFF_BITS-1:0]  eff_len_next;
    logic [wbps_pkg::LEN_BITS-1:0]  len_raw;

    wbps_pkg::cell_ctrl_t  ctrl;
    wbps_pkg::trk_in_t     byte_in;
    wbps_pkg::trk_status_t status;

    logic                                       in_accept;
    logic [wbps_pkg::BYTE_BITS-1:0]             win_bytes [wbps_pkg::MAX_PATTERN+1];
    logic [wbps_pkg::MAX_PATTERN-1:0]           hits;

    assign cfg_ready = 1'b1;

    // Zero length acts as one and lengths past the row saturate.
    assign len_raw = cfg_data[wbps_pkg::LEN_BITS-1:0];
    always_comb begin
        if (len_raw == '0) begin
            eff_len_next = wbps_pkg::EFF_BITS'(1);
        end else if (32'(len_raw) > wbps_pkg::MAX_PATTERN) begin
            eff_len_next = wbps_pkg::EFF_BITS'(wbps_pkg::MAX_PATTERN);
        end else begin
            eff_len_next = wbps_pkg::EFF_BITS'(len_raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_address_reg <= '0;
            eff_len_reg      <= wbps_pkg::EFF_BITS'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                wbps_pkg::REG_BASE_ADDRESS:   base_address_reg <= cfg_data;
                wbps_pkg::REG_PATTERN_LENGTH: eff_len_reg      <= eff_len_next;
                default: ;
            endcase
        end
    end

    assign s_tready  = !status.hold_input;
    assign in_accept = s_tvalid && s_tready;

    assign ctrl.load_en  = in_accept && (s_tuser == wbps_pkg::ACT_LOAD_PATTERN);
    assign ctrl.slot     = s_tdata[wbps_pkg::SLOT_BITS-1:0];
    assign ctrl.shift_en = in_accept && (s_tuser == wbps_pkg::ACT_REGION_BYTE);
    assign ctrl.clear    = status.clear_search;
    assign ctrl.data     = s_tdata[wbps_pkg::SLOT_BITS +: wbps_pkg::BYTE_BITS];

    assign byte_in.accepted = ctrl.shift_en;
    assign byte_in.last     = s_tlast;

    assign win_bytes[wbps_pkg::MAX_PATTERN] = '0;

    for (genvar k = 0; k < wbps_pkg::MAX_PATTERN; k++) begin : g_cell
        wbps_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctrl          (ctrl),
            .cell_slot     (wbps_pkg::SLOT_BITS'(k)),
            .is_tail       (eff_len_reg == wbps_pkg::EFF_BITS'(k + 1)),
            .is_active     (wbps_pkg::EFF_BITS'(k) < eff_len_reg),
            .neighbor_byte (win_bytes[k+1]),
            .window_byte   (win_bytes[k]),
            .hit           (hits[k])
        );
    end

    wbps_tracker u_tracker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_in      (byte_in),
        .all_hit      (&hits),
        .eff_len      (eff_len_reg),
        .base_address (base_address_reg),
        .m_tready     (m_tready),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_found      (m_tuser),
        .m_address    (m_tdata)
    );

endmodule

>>> rtl/core/wbps_cell.sv
// One cell of the row: a pattern byte, a window byte and its compare.
module wbps_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  wbps_pkg::cell_ctrl_t             ctrl,
    input  logic [wbps_pkg::SLOT_BITS-1:0]   cell_slot,
    input  logic                             is_tail,
    input  logic                             is_active,
    input  logic [wbps_pkg::BYTE_BITS-1:0]   neighbor_byte,
    output logic [wbps_pkg::BYTE_BITS-1:0]   window_byte,
    output logic                             hit
);

    logic [wbps_pkg::BYTE_BITS-1:0] pattern_reg;
    logic [wbps_pkg::BYTE_BITS-1:0] window_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load_en && (ctrl.slot == cell_slot)) begin
            pattern_reg <= ctrl.data;
        end
    end

    // The newest byte enters at the tail cell, which sits at the pattern's
    // last position, and older bytes move toward cell zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
        end else if (ctrl.clear) begin
            window_reg <= '0;
        end else if (ctrl.shift_en) begin
            window_reg <= is_tail ? ctrl.data : neighbor_byte;
        end
    end

    assign window_byte = window_reg;
    assign hit = !is_active || (pattern_reg == wbps_pkg::WILDCARD_BYTE)
                 || (pattern_reg == window_reg);

endmodule

>>> rtl/core/wbps_tracker.sv
// Byte count, first-match tracking and the result register.
module wbps_tracker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  wbps_pkg::trk_in_t                  byte_in,
    input  logic                               all_hit,
    input  logic [wbps_pkg::EFF_BITS-1:0]      eff_len,
    input  logic [wbps_pkg::ADDR_BITS-1:0]     base_address,
    input  logic                               m_tready,
    output wbps_pkg::trk_status_t              status,
    output logic                               m_tvalid,
    output logic                               m_found,
    output logic [wbps_pkg::ADDR_BITS-1:0]     m_address
);

    logic                               eval_valid_reg, eval_valid_next;
    logic                               eval_last_reg, eval_last_next;
    logic [wbps_pkg::COUNT_BITS-1:0]    bytes_seen_reg, bytes_seen_next;
    logic                               match_seen_reg, match_seen_next;
    logic [wbps_pkg::OFFSET_BITS-1:0]   match_offset_reg, match_offset_next;
    logic                               out_valid_reg, out_valid_next;
    logic                               out_found_reg, out_found_next;
    logic [wbps_pkg::ADDR_BITS-1:0]     out_addr_reg, out_addr_next;

    logic                               fire;
    logic                               fire_last;
    logic                               count_ge;
    logic [wbps_pkg::COUNT_BITS-1:0]    start;
    logic                               hit_now;
    logic                               seen_now;
    logic [wbps_pkg::OFFSET_BITS-1:0]   offset_now;

    // A result-bearing byte waits here until the output register is free.
    assign fire      = eval_valid_reg && (!eval_last_reg || !out_valid_reg || m_tready);
    assign fire_last = fire && eval_last_reg;

    assign count_ge   = bytes_seen_reg >= wbps_pkg::COUNT_BITS'(eff_len);
    assign start      = bytes_seen_reg - wbps_pkg::COUNT_BITS'(eff_len);
    assign hit_now    = !match_seen_reg && count_ge && !start[wbps_pkg::COUNT_BITS-1]
                        && all_hit;
    assign seen_now   = match_seen_reg || hit_now;
    assign offset_now = hit_now ? start[wbps_pkg::OFFSET_BITS-1:0] : match_offset_reg;

    always_comb begin
        eval_valid_next   = eval_valid_reg;
        eval_last_next    = eval_last_reg;
        bytes_seen_next   = bytes_seen_reg;
        match_seen_next   = match_seen_reg;
        match_offset_next = match_offset_reg;
        out_valid_next    = out_valid_reg;
        out_found_next    = out_found_reg;
        out_addr_next     = out_addr_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        if (fire) begin
            eval_valid_next = 1'b0;
            if (eval_last_reg) begin
                out_valid_next    = 1'b1;
                out_found_next    = seen_now;
                out_addr_next     = seen_now
                                    ? base_address + wbps_pkg::ADDR_BITS'(offset_now)
                                    : '0;
                bytes_seen_next   = '0;
                match_seen_next   = 1'b0;
                match_offset_next = '0;
            end else begin
                match_seen_next   = seen_now;
                match_offset_next = offset_now;
            end
        end

        if (byte_in.accepted) begin
            eval_valid_next = 1'b1;
            eval_last_next  = byte_in.last;
            if (bytes_seen_reg != '1) begin
                bytes_seen_next = bytes_seen_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eval_valid_reg   <= 1'b0;
            eval_last_reg    <= 1'b0;
            bytes_seen_reg   <= '0;
            match_seen_reg   <= 1'b0;
            match_offset_reg <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            eval_valid_reg   <= eval_valid_next;
            eval_last_reg    <= eval_last_next;
            bytes_seen_reg   <= bytes_seen_next;
            match_seen_reg   <= match_seen_next;
            match_offset_reg <= match_offset_next;
            out_valid_reg    <= out_valid_next;
        end
        out_found_reg <= out_found_next;
        out_addr_reg  <= out_addr_next;
    end

    assign status.hold_input   = eval_valid_reg && eval_last_reg;
    assign status.clear_search = fire_last;
    assign m_tvalid            = out_valid_reg;
    assign m_found             = out_found_reg;
    assign m_address           = out_addr_reg;

`ifndef NO_ASSERTIONS
    a_counted_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        eval_valid_reg |-> (bytes_seen_reg != '0))
        else $error("byte under evaluation was not counted");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_last |=> out_valid_reg)
        else $error("region end did not load a result");

    a_stalled_end_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (eval_valid_reg && eval_last_reg && !fire) |=> (eval_valid_reg && eval_last_reg))
        else $error("stalled region end was dropped");

    a_no_match_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_found_reg) |-> (out_addr_reg == '0))
        else $error("address not zero on a miss");
`endif

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the wildcard byte pattern search unit.
module tb_top;
    import wbps_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE_TICKS = 8;
    localparam int WARMUP_LOADS = MAX_PATTERN;
    localparam int PHASE_ITEMS  = 140;

    typedef struct packed {
        logic                 found;
        logic [ADDR_BITS-1:0] addr;
    } hit_report_t;

    typedef enum logic [1:0] {ROW_LOAD, ROW_BYTE, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic [SLOT_BITS-1:0]      slot;
        logic [BYTE_BITS-1:0]      data;
        logic                      last;
        logic                      typed;
        hit_report_t               want;
        logic [CFG_INDEX_BITS-1:0] reg_idx;
        logic [ADDR_BITS-1:0]      reg_val;
    } dir_row_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [15:0]               s_tdata;   // pattern_slot, data_byte
    logic                      s_tuser;   // action
    logic                      s_tlast;   // region_last
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [ADDR_BITS-1:0]      m_tdata;   // match_address
    logic                      m_tuser;   // found
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [ADDR_BITS-1:0]      cfg_data;

    // Scanner state mirrored by the testbench.
    logic [BYTE_BITS-1:0]   pat_mem [MAX_PATTERN];
    logic [BYTE_BITS-1:0]   win [MAX_PATTERN];
    logic [COUNT_BITS-1:0]  seen;
    logic                   hit;
    logic [OFFSET_BITS-1:0] hit_off;
    logic [ADDR_BITS-1:0]   cur_base;
    logic [LEN_BITS-1:0]    cur_len;

    hit_report_t pending_reports [$];
    hit_report_t got;
    dir_row_t    directed_rows [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int items_sent     = 0;
    int regions_sent   = 0;
    int settings_used  = 0;
    int results_seen   = 0;
    int matches_seen   = 0;
    int tx_burst_left  = 0;
    bit tx_quiet       = 1'b0;
    int rx_tick        = 0;
    int rx_mode        = 0;
    int rx_hold        = 0;
    bit rx_low         = 1'b0;

    wildcard_byte_pattern_search_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int unsigned active_length(logic [LEN_BITS-1:0] len);
        if (len == 0)
            return 1;
        if (len > MAX_PATTERN)
            return MAX_PATTERN;
        return len;
    endfunction

    function automatic bit window_hit(int unsigned len);
        logic [BYTE_BITS-1:0] p;
        for (int i = 0; i < len; i++) begin
            p = pat_mem[i];
            if (p != WILDCARD_BYTE && p != win[len - 1 - i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_search();
        foreach (win[i])
            win[i] = '0;
        seen    = '0;
        hit     = 1'b0;
        hit_off = '0;
    endtask

    // Advances the mirrored scanner by one item; rep is valid when produced is set.
    task automatic scan_item(input logic act, input logic [SLOT_BITS-1:0] slot,
                             input logic [BYTE_BITS-1:0] data, input logic last,
                             output bit produced, output hit_report_t rep);
        int unsigned         len;
        logic [COUNT_BITS-1:0] first;
        produced = 1'b0;
        rep      = '0;
        if (act == ACT_LOAD_PATTERN) begin
            pat_mem[slot] = data;
            return;
        end
        for (int i = MAX_PATTERN - 1; i > 0; i--)
            win[i] = win[i - 1];
        win[0] = data;
        if (seen != '1)
            seen = seen + 1'b1;
        len = active_length(cur_len);
        if (!hit && seen >= len) begin
            first = seen - len;
            // A start offset wider than the offset field is never recorded.
            if (first[COUNT_BITS-1] == 1'b0 && window_hit(len)) begin
                hit     = 1'b1;
                hit_off = first[OFFSET_BITS-1:0];
            end
        end
        if (last) begin
            produced   = 1'b1;
            rep.found  = hit;
            rep.addr   = hit ? cur_base + ADDR_BITS'(hit_off) : '0;
            clear_search();
        end
    endtask

    // Called and returns at a falling edge; tvalid stays high on return.
    task automatic send_item(input logic act, input logic [SLOT_BITS-1:0] slot,
                             input logic [BYTE_BITS-1:0] data, input logic last,
                             input logic typed, input hit_report_t want);
        int          gap;
        bit          produced;
        hit_report_t rep;
        if (!tx_quiet && tx_burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            tx_burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 12);
        end
        if (tx_burst_left > 0)
            tx_burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {2'b00, data, slot};
        s_tlast  <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        scan_item(act, slot, data, last, produced, rep);
        if (produced)
            pending_reports.insert(pending_reports.size(), typed ? want : rep);
        items_sent++;
        if (act == ACT_REGION_BYTE && last)
            regions_sent++;
        @(negedge aclk);
    endtask

    // Stops the sender and waits until the block has nothing left in flight.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_TICKS) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [ADDR_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        if (idx == REG_BASE_ADDRESS)
            cur_base = value;
        else
            cur_len = value[LEN_BITS-1:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [BYTE_BITS-1:0] pick_byte();
        case ($urandom_range(0, 3))
            0: return WILDCARD_BYTE;
            1, 2: begin
                case ($urandom_range(0, 3))
                    0: return 8'h00;
                    1: return 8'hFF;
                    2: return 8'h41;
                    default: return 8'h42;
                endcase
            end
            default: return BYTE_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic tweak_pattern(input int unsigned len);
        int                   k;
        logic [SLOT_BITS-1:0] slot;
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) begin
            slot = ($urandom_range(0, 4) == 0) ? SLOT_BITS'($urandom_range(0, MAX_PATTERN - 1))
                                                : SLOT_BITS'($urandom_range(0, len - 1));
            send_item(ACT_LOAD_PATTERN, slot, pick_byte(), ($urandom_range(0, 7) == 0),
                      1'b0, '0);
        end
    endtask

    // Builds one region, mostly with the current pattern planted in it.
    task automatic send_region(input int unsigned len);
        logic [BYTE_BITS-1:0] region_bytes [$];
        int                   n;
        int                   pos;
        int                   shape;
        int                   plants;
        shape = $urandom_range(0, 9);
        if (shape == 0)
            n = (len > 1) ? $urandom_range(1, len - 1) : 1;
        else
            n = $urandom_range(len, len + 24);
        if ($urandom_range(0, 19) == 0)
            n += $urandom_range(100, 400);
        for (int i = 0; i < n; i++)
            region_bytes.insert(region_bytes.size(), pick_byte());
        plants = (shape >= 3) ? $urandom_range(1, 2) : 0;
        for (int j = 0; j < plants; j++) begin
            pos = $urandom_range(0, n - len);
            for (int i = 0; i < len; i++)
                if (pat_mem[i] != WILDCARD_BYTE)
                    region_bytes[pos + i] = pat_mem[i];
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 24) == 0)
                send_item(ACT_LOAD_PATTERN, SLOT_BITS'($urandom_range(0, MAX_PATTERN - 1)),
                          pick_byte(), 1'($urandom_range(0, 1)), 1'b0, '0);
            send_item(ACT_REGION_BYTE, SLOT_BITS'($urandom_range(0, MAX_PATTERN - 1)),
                      region_bytes[i], (i == n - 1), 1'b0, '0);
        end
    endtask

    task automatic run_phase(input logic [ADDR_BITS-1:0] base,
                             input logic [LEN_BITS-1:0] len, input bit quiet);
        int          first_item;
        int unsigned eff;
        settle();
        write_reg(REG_BASE_ADDRESS, base);
        write_reg(REG_PATTERN_LENGTH, ADDR_BITS'(len));
        settings_used++;
        tx_quiet   = quiet;
        eff        = active_length(cur_len);
        first_item = items_sent;
        while (items_sent - first_item < PHASE_ITEMS) begin
            if ($urandom_range(0, 3) == 0)
                tweak_pattern(eff);
            send_region(eff);
        end
    endtask

    function automatic dir_row_t row_load(logic [SLOT_BITS-1:0] slot,
                                          logic [BYTE_BITS-1:0] data, logic last);
        dir_row_t r;
        r      = '{kind: ROW_LOAD, default: '0};
        r.slot = slot;
        r.data = data;
        r.last = last;
        return r;
    endfunction

    function automatic dir_row_t row_byte(logic [BYTE_BITS-1:0] data, logic last);
        dir_row_t r;
        r      = '{kind: ROW_BYTE, default: '0};
        r.data = data;
        r.last = last;
        return r;
    endfunction

    function automatic dir_row_t row_byte_want(logic [BYTE_BITS-1:0] data, logic found,
                                               logic [ADDR_BITS-1:0] addr);
        dir_row_t r;
        r            = row_byte(data, 1'b1);
        r.typed      = 1'b1;
        r.want.found = found;
        r.want.addr  = addr;
        return r;
    endfunction

    function automatic dir_row_t row_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                         logic [ADDR_BITS-1:0] value);
        dir_row_t r;
        r         = '{kind: ROW_REG, default: '0};
        r.reg_idx = idx;
        r.reg_val = value;
        return r;
    endfunction

    function automatic void add_row(dir_row_t r);
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            results_seen++;
            if (m_tuser === 1'b1)
                matches_seen++;
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                $error("Unexpected result item: found=%0b match_address=%h", m_tuser, m_tdata);
            end else begin
                got = pending_reports.pop_front();
                if (m_tuser !== got.found) begin
                    mismatch_count++;
                    $error("found: expected %0b, actual %0b", got.found, m_tuser);
                end
                if (m_tdata !== got.addr) begin
                    mismatch_count++;
                    $error("match_address: expected %h, actual %h", got.addr, m_tdata);
                end
            end
        end
    end

    // Receiver readiness cycles through several stall patterns.
    always @(negedge aclk) begin
        rx_tick++;
        if (rx_tick % 200 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: begin
                if (rx_hold == 0) begin
                    rx_low  = !rx_low;
                    rx_hold = rx_low ? $urandom_range(1, 24) : $urandom_range(1, 4);
                end
                rx_hold--;
                m_tready <= !rx_low;
            end
            default: m_tready <= (rx_tick % 4 != 0);
        endcase
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_LOAD_PATTERN;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_BASE_ADDRESS;
        cfg_data  = '0;
        cur_base  = '0;
        cur_len   = LEN_BITS'(1);
        foreach (pat_mem[i])
            pat_mem[i] = '0;
        clear_search();

        add_row(row_load(6'd0, 8'h41, 1'b0));
        // A tlast on a pattern load must be ignored.
        add_row(row_load(6'd63, 8'h00, 1'b1));
        add_row(row_byte_want(8'h41, 1'b1, 64'h0));
        add_row(row_byte_want(8'h00, 1'b0, 64'h0));
        add_row(row_reg(REG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF));
        add_row(row_reg(REG_PATTERN_LENGTH, 64'h0));
        add_row(row_load(6'd0, 8'hFF, 1'b0));
        add_row(row_byte(8'h00, 1'b0));
        // The match address wraps past the top of the address space.
        add_row(row_byte_want(8'hFF, 1'b1, 64'h0));
        add_row(row_load(6'd0, WILDCARD_BYTE, 1'b0));
        add_row(row_byte_want(8'h80, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
        add_row(row_reg(REG_BASE_ADDRESS, 64'h1000));
        add_row(row_reg(REG_PATTERN_LENGTH, 64'd3));
        add_row(row_load(6'd1, 8'hFF, 1'b0));
        add_row(row_load(6'd2, 8'h00, 1'b0));
        // Region shorter than the pattern never compares.
        add_row(row_byte(8'h12, 1'b0));
        add_row(row_byte_want(8'hFF, 1'b0, 64'h0));
        // Two matching starts; only the first one is reported.
        add_row(row_byte(8'h00, 1'b0));
        add_row(row_byte(8'h7E, 1'b0));
        add_row(row_byte(8'hFF, 1'b0));
        add_row(row_byte(8'h00, 1'b0));
        add_row(row_byte(8'hFF, 1'b0));
        add_row(row_byte_want(8'h00, 1'b1, 64'h1001));
        add_row(row_load(6'd63, 8'hFF, 1'b0));

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        settings_used = 1;
        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_REG: begin
                    settle();
                    write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
                    settings_used++;
                end
                ROW_LOAD: send_item(ACT_LOAD_PATTERN, directed_rows[i].slot,
                                    directed_rows[i].data, directed_rows[i].last, 1'b0, '0);
                default: send_item(ACT_REGION_BYTE, directed_rows[i].slot,
                                   directed_rows[i].data, directed_rows[i].last,
                                   directed_rows[i].typed, directed_rows[i].want);
            endcase
        end

        // Every slot gets a value before any long pattern is compared.
        for (int i = 0; i < WARMUP_LOADS; i++)
            send_item(ACT_LOAD_PATTERN, SLOT_BITS'(i), pick_byte(), 1'b0, 1'b0, '0);

        run_phase(64'h0, 7'd1, 1'b0);
        run_phase(64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 1'b1);
        run_phase({$urandom, $urandom}, 7'd127, 1'b0);
        run_phase({$urandom, $urandom}, 7'd0, 1'b0);
        run_phase(64'hFFFF_FFFF_FFFF_FFF0, LEN_BITS'($urandom_range(2, 6)), 1'b1);
        run_phase({$urandom, $urandom}, LEN_BITS'($urandom_range(2, 16)), 1'b0);
        run_phase({$urandom, $urandom}, LEN_BITS'($urandom_range(17, 63)), 1'b0);
        run_phase({$urandom, $urandom}, LEN_BITS'($urandom_range(2, 8)), 1'b1);

        settle();
        repeat (SETTLE_TICKS) @(negedge aclk);
        $display("Sent %0d items in %0d regions across %0d register settings.",
                 items_sent, regions_sent, settings_used);
        $display("Checked %0d result items, %0d of them reporting a match.",
                 results_seen, matches_seen);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
rtl/core/wbps_pkg.sv
rtl/core/wbps_cell.sv
rtl/core/wbps_tracker.sv
rtl/core/wildcard_byte_pattern_search_unit.sv
tb/sv/tb_top.sv
